### src/move_to_front_codec_defines.svh
// assertion macros for the move-to-front codec checker
// expects signals named clk and rst in the scope that uses them
`ifndef MOVE_TO_FRONT_CODEC_DEFINES_SVH
`define MOVE_TO_FRONT_CODEC_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define MTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtf check failed: next-cycle property");

// consequent must hold in the same cycle as the antecedent
`define MTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtf check failed: same-cycle property");

`endif

### src/mtf_pkg.sv
// shared types and constants for the move-to-front codec
// no dependencies
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int SYM_W       = 8;
  localparam int GROUP_CELLS = 16;

  typedef logic [SYM_W-1:0] sym_t;

  // broadcast control from the sequencer to every list cell
  typedef struct packed {
    logic load_id;
    logic move;
    logic decode;
    sym_t key;
    sym_t pos;
  } cell_ctl_t;

endpackage

### src/mtf_cell.sv
// one entry of the recency list: holds a symbol, compares it, shifts from its neighbor
// depends on mtf_pkg
`timescale 1ns / 1ps

module mtf_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  mtf_pkg::cell_ctl_t ctl,
  input  mtf_pkg::sym_t     prev_entry,
  output mtf_pkg::sym_t     entry,
  output logic              hit,
  output mtf_pkg::sym_t     tag
);
  import mtf_pkg::*;

  localparam sym_t IDX = sym_t'(INDEX);

  // identity on reset or stream start, shift back when in front of the moved entry
  always_ff @(posedge clk) begin
    if (rst || ctl.load_id) begin
      entry <= IDX;
    end else if (ctl.move && (IDX <= ctl.pos)) begin
      entry <= prev_entry;
    end
  end

  // encode matches on content, decode matches on position
  assign hit = ctl.decode ? (ctl.key == IDX) : (entry == ctl.key);
  assign tag = ctl.decode ? entry : IDX;

endmodule

### src/mtf_group.sv
// registered or-reduction of the tags of one group of list cells
// depends on mtf_pkg
`timescale 1ns / 1ps

module mtf_group (
  input  logic                                       clk,
  input  logic [mtf_pkg::GROUP_CELLS-1:0]            hit,
  input  mtf_pkg::sym_t [mtf_pkg::GROUP_CELLS-1:0]   tags,
  output logic                                       any_hit,
  output mtf_pkg::sym_t                              sel_tag
);
  import mtf_pkg::*;

  sym_t acc;

  // at most one cell hits, so an or of masked tags selects it
  always_comb begin
    acc = '0;
    for (int i = 0; i < GROUP_CELLS; i++) begin
      if (hit[i]) begin
        acc = acc | tags[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    any_hit <= |hit;
    sel_tag <= acc;
  end

endmodule

### src/move_to_front_codec.sv
// move-to-front codec top level: list cells, group reduction, sequencer, apb register
// depends on mtf_pkg, mtf_cell, mtf_group
//
//   channel  direction  handshake             payload
//   in       into       in_valid / in_stall   in_symbol, stream_start
//   out      out of     out_valid / out_stall out_symbol
//   cfg      into       apb psel / penable    decode_mode at byte address 0
//
// an item passes through compare and group or, final or, and shift,
// after a reload of the identity list when stream_start is set; the next beat is taken
// in the shift state when the result can move, so results drain while the next item runs
// reset loads the identity list into all cells directly, no clearing pass
// a stalled result holds the shift; a new beat is taken while a result waits
`timescale 1ns / 1ps

module move_to_front_codec #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_stall,
  input  mtf_pkg::sym_t in_symbol,
  input  logic          stream_start,
  output logic          out_valid,
  input  logic          out_stall,
  output mtf_pkg::sym_t out_symbol
);
  import mtf_pkg::*;

  localparam int GROUPS = (ALPHABET_SIZE + GROUP_CELLS - 1) / GROUP_CELLS;
  localparam int PAD    = GROUPS * GROUP_CELLS;
  localparam logic [SYM_W:0] NOT_FOUND = (SYM_W + 1)'(ALPHABET_SIZE);
  localparam logic [0:0] REG_DECODE_MODE = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_REDUCE = 5'b01000,
    ST_MOVE   = 5'b10000
  } state_t;

  state_t    state, state_next;
  logic      decode_mode;
  sym_t      key;
  logic      found;
  sym_t      found_tag;
  logic      in_beat;
  logic      move_go;
  logic      cfg_write;
  sym_t      front;
  sym_t      result;
  cell_ctl_t ctl;

  sym_t [ALPHABET_SIZE-1:0] entry;
  sym_t [ALPHABET_SIZE-1:0] prev;
  logic [PAD-1:0]           cell_hit;
  sym_t [PAD-1:0]           cell_tag;
  logic [GROUPS-1:0]        grp_hit;
  sym_t [GROUPS-1:0]        grp_tag;
  sym_t                     red_tag;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2:2] == REG_DECODE_MODE) ? 32'(decode_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
    end else if (cfg_write && (paddr[2:2] == REG_DECODE_MODE)) begin
      decode_mode <= pwdata[0];
    end
  end

  // handshake
  assign move_go  = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) || ((state == ST_MOVE) && move_go));
  assign in_beat  = in_valid && !in_stall;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = stream_start ? ST_LOAD : ST_SCAN;
        end
      end
      ST_LOAD:   state_next = ST_SCAN;
      ST_SCAN:   state_next = ST_REDUCE;
      ST_REDUCE: state_next = ST_MOVE;
      ST_MOVE: begin
        if (move_go) begin
          if (in_beat) begin
            state_next = stream_start ? ST_LOAD : ST_SCAN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item key
  always_ff @(posedge clk) begin
    if (in_beat) begin
      key <= in_symbol;
    end
  end

  // cell control broadcast
  assign front = decode_mode ? found_tag : key;

  always_comb begin
    ctl.load_id = (state == ST_LOAD);
    ctl.move    = (state == ST_MOVE) && move_go && found;
    ctl.decode  = decode_mode;
    ctl.key     = key;
    ctl.pos     = decode_mode ? key : found_tag;
  end

  // row of list cells, each shifting from its front neighbor
  assign prev[0] = front;

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign prev[i] = entry[i-1];
    end
    mtf_cell #(
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev_entry(prev[i]),
      .entry     (entry[i]),
      .hit       (cell_hit[i]),
      .tag       (cell_tag[i])
    );
  end

  // unused slots of the last group never hit
  for (genvar p = ALPHABET_SIZE; p < PAD; p++) begin : g_pad
    assign cell_hit[p] = 1'b0;
    assign cell_tag[p] = '0;
  end

  // first reduction level
  for (genvar g = 0; g < GROUPS; g++) begin : g_group
    mtf_group u_group (
      .clk    (clk),
      .hit    (cell_hit[g*GROUP_CELLS +: GROUP_CELLS]),
      .tags   (cell_tag[g*GROUP_CELLS +: GROUP_CELLS]),
      .any_hit(grp_hit[g]),
      .sel_tag(grp_tag[g])
    );
  end

  // second reduction level
  always_comb begin
    red_tag = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (grp_hit[g]) begin
        red_tag = red_tag | grp_tag[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REDUCE) begin
      found     <= |grp_hit;
      found_tag <= red_tag;
    end
  end

  // result: the found tag, else the not-found code when encoding, zero when decoding
  always_comb begin
    if (found) begin
      result = found_tag;
    end else if (decode_mode) begin
      result = '0;
    end else begin
      result = NOT_FOUND[SYM_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_MOVE) && move_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_MOVE) && move_go) begin
      out_symbol <= result;
    end
  end

endmodule

### src/mtf_checker.sv
// port-level checks for the move-to-front codec, bound to the top level
// depends on mtf_pkg and move_to_front_codec_defines.svh
`timescale 1ns / 1ps
`include "move_to_front_codec_defines.svh"

module mtf_checker (
  input logic          clk,
  input logic          rst,
  input logic          psel,
  input logic          penable,
  input logic          pwrite,
  input logic [2:0]    paddr,
  input logic [31:0]   pwdata,
  input logic [31:0]   prdata,
  input logic          pready,
  input logic          in_valid,
  input logic          in_stall,
  input mtf_pkg::sym_t in_symbol,
  input logic          stream_start,
  input logic          out_valid,
  input logic          out_stall,
  input mtf_pkg::sym_t out_symbol
);
  import mtf_pkg::*;

  logic in_beat;
  logic mode_write;

  assign in_beat    = in_valid && !in_stall;
  assign mode_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  // one item at a time: the block is busy right after taking a beat
  `MTF_ASSERT_NEXT(a_busy_after_beat, in_beat && !rst, in_stall)

  // a stalled input beat stays put
  `MTF_ASSERT_NEXT(a_in_hold, in_valid && in_stall && !rst,
                   in_valid && $stable(in_symbol) && $stable(stream_start))

  // a stalled result beat stays put
  `MTF_ASSERT_NEXT(a_out_hold, out_valid && out_stall && !rst,
                   out_valid && $stable(out_symbol))

  // mode register reads back what was written
  `MTF_ASSERT_NOW(a_mode_readback, $past(mode_write) && !$past(rst) && (paddr[2] == 1'b0),
                  prdata[0] == $past(pwdata[0]))

endmodule

bind move_to_front_codec mtf_checker u_mtf_checker (
  .clk         (clk),
  .rst         (rst),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_symbol   (in_symbol),
  .stream_start(stream_start),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_symbol  (out_symbol)
);
